@@ rtl/cpc_pkg.sv @@
`timescale 1ns / 1ps
package cpc_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int LANES      = 3;
	localparam int IN_BYTES_W = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W      = 8;

	typedef enum logic [1:0] {
		VERD_CONVEX = 2'd0,
		VERD_FEW    = 2'd1,
		VERD_FLAT   = 2'd2,
		VERD_SIGN   = 2'd3
	} verdict_t;

	// edge deltas of one vertex triple (a, b, c)
	typedef struct packed {
		logic signed [DIFF_W-1:0] dxab;
		logic signed [DIFF_W-1:0] dyac;
		logic signed [DIFF_W-1:0] dyab;
		logic signed [DIFF_W-1:0] dxac;
	} triple_t;

	// lane 0: triple closed by this vertex, lanes 1 and 2: wrap-around triples
	typedef struct packed {
		triple_t [LANES-1:0] tr;
		logic [LANES-1:0]    tvld;
		logic                first_turn;
		logic                last;
		logic                too_few;
	} job_t;

	function automatic logic signed [DIFF_W-1:0] delta(
		input logic signed [COORD_BITS-1:0] from_c,
		input logic signed [COORD_BITS-1:0] to_c
	);
		logic signed [DIFF_W-1:0] ext_from;
		logic signed [DIFF_W-1:0] ext_to;
		ext_from = DIFF_W'(from_c);
		ext_to   = DIFF_W'(to_c);
		return ext_to - ext_from;
	endfunction

	function automatic triple_t make_triple(
		input logic signed [COORD_BITS-1:0] ax,
		input logic signed [COORD_BITS-1:0] ay,
		input logic signed [COORD_BITS-1:0] bx,
		input logic signed [COORD_BITS-1:0] by,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy
	);
		triple_t t;
		t.dxab = delta(ax, bx);
		t.dyac = delta(ay, cy);
		t.dyab = delta(ay, by);
		t.dxac = delta(ax, cx);
		return t;
	endfunction

endpackage

@@ rtl/cpc_front.sv @@
`timescale 1ns / 1ps
module cpc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic signed [cpc_pkg::COORD_BITS-1:0] x,
	input  logic signed [cpc_pkg::COORD_BITS-1:0] y,
	input  logic                                 last_vertex,
	input  logic                                 q_full,
	output logic                                 q_push,
	output cpc_pkg::job_t                        q_job
);

	logic signed [cpc_pkg::COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [cpc_pkg::COORD_BITS-1:0] second_x_q, second_y_q;
	logic signed [cpc_pkg::COORD_BITS-1:0] older_x_q, older_y_q;
	logic signed [cpc_pkg::COORD_BITS-1:0] newer_x_q, newer_y_q;
	logic [1:0]                            count_q;
	logic                                  closes;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;
	assign closes   = count_q >= 2'd2;

	always_comb begin
		q_job.tr[0]      = cpc_pkg::make_triple(older_x_q, older_y_q, newer_x_q, newer_y_q, x, y);
		q_job.tr[1]      = cpc_pkg::make_triple(newer_x_q, newer_y_q, x, y, first_x_q, first_y_q);
		q_job.tr[2]      = cpc_pkg::make_triple(x, y, first_x_q, first_y_q, second_x_q, second_y_q);
		q_job.tvld[0]    = closes;
		q_job.tvld[1]    = closes && last_vertex;
		q_job.tvld[2]    = closes && last_vertex;
		q_job.first_turn = count_q == 2'd2;
		q_job.last       = last_vertex;
		q_job.too_few    = last_vertex && !closes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (q_push) begin
			if (last_vertex) begin
				count_q <= 2'd0;
			end else if (count_q != 2'd3) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			if (count_q == 2'd0) begin
				first_x_q <= x;
				first_y_q <= y;
			end
			if (count_q == 2'd1) begin
				second_x_q <= x;
				second_y_q <= y;
			end
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			newer_x_q <= x;
			newer_y_q <= y;
		end
	end

endmodule

@@ rtl/cpc_fifo.sv @@
`timescale 1ns / 1ps
module cpc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpc_pkg::job_t push_job,
	input  logic          pop,
	output cpc_pkg::job_t pop_job,
	output logic          not_empty,
	output logic          full
);

	cpc_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign not_empty = fill_q != 2'd0;
	assign full      = fill_q == 2'd2;
	assign pop_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/cpc_back.sv @@
`timescale 1ns / 1ps
module cpc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  cpc_pkg::job_t q_job,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic          is_convex_flag,
	output logic [1:0]    verdict
);

	logic signed [cpc_pkg::PROD_W-1:0] pa_s1 [cpc_pkg::LANES];
	logic signed [cpc_pkg::PROD_W-1:0] pb_s1 [cpc_pkg::LANES];
	logic [cpc_pkg::LANES-1:0]         tvld_s1;
	logic                              first_s1, last_s1, few_s1, valid_s1;
	logic                              out_free, adv_s1;

	cpc_pkg::verdict_t pend_q, pend_d, verdict_q;
	logic              ref_q, ref_d;
	logic              out_valid_q;

	logic signed [cpc_pkg::CROSS_W-1:0] cross_val [cpc_pkg::LANES];
	logic [cpc_pkg::LANES-1:0]          neg, zero;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign q_pop    = q_not_empty && (!valid_s1 || adv_s1);

	always_comb begin
		for (int i = 0; i < cpc_pkg::LANES; i++) begin
			cross_val[i] = cpc_pkg::CROSS_W'(pa_s1[i]) - cpc_pkg::CROSS_W'(pb_s1[i]);
			neg[i]       = cross_val[i][cpc_pkg::CROSS_W-1];
			zero[i]      = cross_val[i] == '0;
		end
	end

	// first failing turn in stream order wins
	always_comb begin
		pend_d = pend_q;
		ref_d  = ref_q;
		if (tvld_s1[0] && first_s1) begin
			if (zero[0]) begin
				pend_d = cpc_pkg::VERD_FLAT;
			end else begin
				ref_d = neg[0];
			end
		end
		for (int i = 0; i < cpc_pkg::LANES; i++) begin
			if (tvld_s1[i] && !(i == 0 && first_s1) && pend_d == cpc_pkg::VERD_CONVEX) begin
				if (zero[i]) begin
					pend_d = cpc_pkg::VERD_FLAT;
				end else if (neg[i] != ref_d) begin
					pend_d = cpc_pkg::VERD_SIGN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= cpc_pkg::VERD_CONVEX;
			ref_q       <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				if (last_s1) begin
					pend_q <= cpc_pkg::VERD_CONVEX;
					ref_q  <= 1'b0;
				end else begin
					pend_q <= pend_d;
					ref_q  <= ref_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < cpc_pkg::LANES; i++) begin
				pa_s1[i] <= cpc_pkg::PROD_W'(q_job.tr[i].dxab) * cpc_pkg::PROD_W'(q_job.tr[i].dyac);
				pb_s1[i] <= cpc_pkg::PROD_W'(q_job.tr[i].dyab) * cpc_pkg::PROD_W'(q_job.tr[i].dxac);
			end
			tvld_s1  <= q_job.tvld;
			first_s1 <= q_job.first_turn;
			last_s1  <= q_job.last;
			few_s1   <= q_job.too_few;
		end
		if (adv_s1 && last_s1) begin
			verdict_q <= few_s1 ? cpc_pkg::VERD_FEW : pend_d;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign verdict        = verdict_q;
	assign is_convex_flag = verdict_q == cpc_pkg::VERD_CONVEX;

endmodule

@@ rtl/convex_polygon_check_core.sv @@
`timescale 1ns / 1ps
// convex polygon check: strict convexity test over a stream of vertices
// input s_*: one vertex per word, tdata = {y, x} (x in the low half), tlast
// on the final vertex of a polygon; coordinates are signed two's complement
// output m_*: one word per polygon, sent after its tlast vertex:
// bit 0 is_convex_flag, bits 2:1 verdict (0 convex, 1 fewer than three
// vertices, 2 collinear turn, 3 turn sign changed), upper bits zero
// throughput: one vertex per cycle while s_tready is high; the front stores
// the vertices and forms the edge deltas of up to three triples per word,
// the back computes all three cross products in parallel lanes, one
// multiplier pair per lane; the verdict is registered to drive m_tvalid
// a two-entry queue sits between front and back, so a stalled m_tready
// backs up first the result register, then the queue, and only then drops
// s_tready; words without tlast keep draining while the result waits
// reset clears the vertex count, the turn reference, the queue and the
// output valid; no clearing pass is needed and a new polygon may start at once
module convex_polygon_check_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cpc_pkg::IN_BYTES_W-1:0]    s_tdata,   // x, y
	input  logic                              s_tlast,   // last_vertex
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cpc_pkg::OUT_W-1:0]         m_tdata    // is_convex_flag, verdict
);

	cpc_pkg::job_t push_job, pop_job;
	logic          q_push, q_pop, q_full, q_not_empty;
	logic          is_convex_flag;
	logic [1:0]    verdict;

	cpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.x           (s_tdata[cpc_pkg::COORD_BITS-1:0]),
		.y           (s_tdata[2*cpc_pkg::COORD_BITS-1:cpc_pkg::COORD_BITS]),
		.last_vertex (s_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	cpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.pop       (q_pop),
		.pop_job   (pop_job),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	cpc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_job          (pop_job),
		.q_pop          (q_pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.is_convex_flag (is_convex_flag),
		.verdict        (verdict)
	);

	assign m_tdata = {(cpc_pkg::OUT_W - 3)'(0), verdict, is_convex_flag};

endmodule

@@ rtl/cpc_checker.sv @@
`timescale 1ns / 1ps
module cpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [cpc_pkg::IN_BYTES_W-1:0] s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cpc_pkg::OUT_W-1:0]      m_tdata
);

	// polygons closed on the input but not yet delivered
	logic [3:0] open_q;
	logic       in_last, out_word;

	assign in_last  = s_tvalid && s_tready && s_tlast;
	assign out_word = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 4'd0;
		end else if (in_last && !out_word) begin
			open_q <= open_q + 4'd1;
		end else if (out_word && !in_last) begin
			open_q <= open_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[2:1] == 2'd0))
		else $error("convex flag disagrees with verdict");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[cpc_pkg::OUT_W-1:3] == '0)
		else $error("padding bits set in result word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> open_q != 4'd0)
		else $error("result word without a closed polygon");

	a_ready_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 4'd0 |-> s_tready)
		else $error("input stalled with no polygon pending");

endmodule

bind convex_polygon_check_core cpc_checker u_cpc_checker (.*);

@@ tb/convex_polygon_check_core_test.sv @@
`timescale 1ns / 1ps
module convex_polygon_check_core_test;

	localparam int CW          = cpc_pkg::COORD_BITS;
	localparam int RAND_ITEMS  = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 800;
	localparam int HOLD_AFTER  = 100;
	localparam int TAIL_CYCLES = 12;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		bit                   last;
		bit                   drain;
		int                   gap;
	} vertex_word_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [cpc_pkg::IN_BYTES_W-1:0] s_tdata;
	logic                           s_tlast;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [cpc_pkg::OUT_W-1:0]      m_tdata;

	convex_polygon_check_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	vertex_word_t      vertex_q[$];
	cpc_pkg::verdict_t verdict_q[$];

	int cycle_count;
	int in_count;
	int out_count;
	int offer_count;
	int queued_count;
	int mismatch_count;
	int polygon_count;
	int verdict_hits[4];

	// shadow copy of the polygon state
	logic signed [CW-1:0] first_vx, first_vy, second_vx, second_vy;
	logic signed [CW-1:0] older_vx, older_vy, newer_vx, newer_vy;
	int                   seen_verts;
	bit                   turn_neg;
	cpc_pkg::verdict_t    first_fail;

	// stimulus build helpers
	int px[64];
	int py[64];
	bit drain_next;
	bit tx_fast;

	// sender and receiver pacing
	int tx_wait;
	int rx_wait;
	int rx_seen;
	bit rx_fast;
	int hold_left;
	bit hold_done;

	function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		longint t;
		t = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		return (t > 0) ? 1 : ((t < 0) ? -1 : 0);
	endfunction

	function automatic void judge_turn(int t, bit is_first);
		if (is_first) begin
			if (t == 0)
				first_fail = cpc_pkg::VERD_FLAT;
			else
				turn_neg = (t < 0);
			return;
		end
		if (first_fail != cpc_pkg::VERD_CONVEX)
			return;
		if (t == 0)
			first_fail = cpc_pkg::VERD_FLAT;
		else if ((t < 0) != turn_neg)
			first_fail = cpc_pkg::VERD_SIGN;
	endfunction

	function automatic void clear_polygon();
		first_vx = '0; first_vy = '0; second_vx = '0; second_vy = '0;
		older_vx = '0; older_vy = '0; newer_vx = '0; newer_vy = '0;
		seen_verts = 0;
		turn_neg = 1'b0;
		first_fail = cpc_pkg::VERD_CONVEX;
	endfunction

	function automatic void predict_vertex(logic signed [CW-1:0] vx,
		logic signed [CW-1:0] vy, bit last);
		cpc_pkg::verdict_t v;
		if (seen_verts == 0) begin
			first_vx = vx;
			first_vy = vy;
		end else if (seen_verts == 1) begin
			second_vx = vx;
			second_vy = vy;
		end else begin
			judge_turn(turn_sign(older_vx, older_vy, newer_vx, newer_vy, vx, vy),
				seen_verts == 2);
		end
		older_vx = newer_vx;
		older_vy = newer_vy;
		newer_vx = vx;
		newer_vy = vy;
		if (seen_verts < 3)
			seen_verts++;
		if (!last)
			return;
		if (seen_verts < 3) begin
			v = cpc_pkg::VERD_FEW;
		end else begin
			// the two wrap-around triples close the polygon
			judge_turn(turn_sign(older_vx, older_vy, newer_vx, newer_vy,
				first_vx, first_vy), 1'b0);
			judge_turn(turn_sign(newer_vx, newer_vy, first_vx, first_vy,
				second_vx, second_vy), 1'b0);
			v = first_fail;
		end
		verdict_q.insert(verdict_q.size(), v);
		clear_polygon();
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic push_vertex(int x, int y, bit last);
		vertex_word_t w;
		w.x = CW'(clamp_coord(x));
		w.y = CW'(clamp_coord(y));
		w.last = last;
		w.drain = drain_next;
		w.gap = tx_fast ? 0 : int'($urandom_range(0, 19));
		drain_next = 1'b0;
		vertex_q.insert(vertex_q.size(), w);
		queued_count++;
	endtask

	task automatic push_polygon(int n);
		for (int k = 0; k < n; k++)
			push_vertex(px[k], py[k], k == n - 1);
		polygon_count++;
	endtask

	// points on a circle at increasing angles, either direction
	task automatic make_round(int n, int radius);
		int  cx, cy;
		real a, dir, two_pi;
		two_pi = 6.283185307179586;
		cx = int'($urandom_range(0, 32000)) - 16000;
		cy = int'($urandom_range(0, 32000)) - 16000;
		dir = $urandom_range(0, 1) ? 1.0 : -1.0;
		for (int k = 0; k < n; k++) begin
			a = dir * two_pi * (k + 0.8 * ($urandom_range(0, 1000) / 1000.0)) / n;
			px[k] = cx + $rtoi(radius * $cos(a));
			py[k] = cy + $rtoi(radius * $sin(a));
		end
	endtask

	task automatic build_random_polygon();
		int n, k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				n = $urandom_range(3, 10);
				make_round(n, $urandom_range(50, 16000));
			end
			4: begin
				// convex outline with one vertex pushed out of place
				n = $urandom_range(4, 10);
				make_round(n, $urandom_range(500, 16000));
				k = $urandom_range(0, n - 1);
				px[k] += int'($urandom_range(0, 6000)) - 3000;
				py[k] += int'($urandom_range(0, 6000)) - 3000;
			end
			5: begin
				// repeated vertex gives a zero turn somewhere in the run
				n = $urandom_range(4, 9);
				make_round(n, $urandom_range(1000, 16000));
				k = $urandom_range(1, n - 1);
				px[k] = px[k - 1];
				py[k] = py[k - 1];
			end
			6: begin
				n = $urandom_range(1, 6);
				for (int j = 0; j < n; j++) begin
					px[j] = rand_coord();
					py[j] = rand_coord();
				end
			end
			7: begin
				// full-range box, any start corner, either direction
				int cxs[4] = '{-32768, 32767, 32767, -32768};
				int cys[4] = '{-32768, -32768, 32767, 32767};
				bit rev;
				n = 4;
				k = $urandom_range(0, 3);
				rev = $urandom_range(0, 1);
				for (int j = 0; j < 4; j++) begin
					px[j] = cxs[rev ? (k + 4 - j) % 4 : (k + j) % 4];
					py[j] = cys[rev ? (k + 4 - j) % 4 : (k + j) % 4];
				end
			end
			8: begin
				n = $urandom_range(11, 60);
				make_round(n, $urandom_range(12000, 16000));
			end
			default: begin
				n = $urandom_range(1, 2);
				for (int j = 0; j < n; j++) begin
					px[j] = rand_coord();
					py[j] = rand_coord();
				end
			end
		endcase
		push_polygon(n);
	endtask

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		clear_polygon();
		drain_next = 1'b0;
		tx_fast = 1'b0;

		// directed: tiny polygons at the corners of the range
		px[0] = -32768; py[0] = -32768;
		push_polygon(1);
		px[0] = 32767; py[0] = 32767; px[1] = -32768; py[1] = 32767;
		push_polygon(2);
		px[0] = -32768; py[0] = -32768; px[1] = 32767; py[1] = -32768;
		px[2] = 32767; py[2] = 32767;
		push_polygon(3);
		px[0] = 32767; py[0] = 32767; px[1] = 32767; py[1] = -32768;
		px[2] = -32768; py[2] = -32768;
		push_polygon(3);
		// zero first turn
		px[0] = 0; py[0] = 0; px[1] = 1; py[1] = 1; px[2] = 2; py[2] = 2;
		px[3] = 5; py[3] = 0;
		push_polygon(4);
		// self-crossing quad flips the turn sign
		px[0] = 0; py[0] = 0; px[1] = 10; py[1] = 0; px[2] = 0; py[2] = 10;
		px[3] = 10; py[3] = 10;
		push_polygon(4);
		// zero turn after the first one
		px[0] = 0; py[0] = 0; px[1] = 10; py[1] = 0; px[2] = 10; py[2] = 10;
		px[3] = 5; py[3] = 10; px[4] = 0; py[4] = 10;
		push_polygon(5);
		// zero turn only on a wrap-around triple
		px[0] = 0; py[0] = 0; px[1] = 10; py[1] = 0; px[2] = 10; py[2] = 10;
		px[3] = 0; py[3] = 10; px[4] = 0; py[4] = 5;
		push_polygon(5);

		drain_next = 1'b1;
		while (queued_count < RAND_ITEMS) begin
			if ($urandom_range(0, 11) == 0)
				tx_fast = ~tx_fast;
			if ($urandom_range(0, 59) == 0)
				drain_next = 1'b1;
			build_random_polygon();
		end

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		wait (in_count == queued_count);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d polygons, %0d vertices, %0d results in %0d cycles",
			polygon_count, in_count, out_count, cycle_count);
		$display("verdicts seen: convex %0d, too few %0d, collinear %0d, sign flip %0d",
			verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAIL");
		end
		$finish;
	end

	// sampling, prediction and checking
	always @(posedge clk) begin
		cpc_pkg::verdict_t         want;
		logic [cpc_pkg::OUT_W-1:0] want_word;
		logic signed [CW-1:0]      vx, vy;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				out_count++;
				if (verdict_q.size() == 0) begin
					note_mismatch($sformatf("result word %h with nothing expected", m_tdata));
				end else begin
					want = verdict_q.pop_front();
					verdict_hits[want]++;
					want_word = '0;
					want_word[0] = (want == cpc_pkg::VERD_CONVEX);
					want_word[2:1] = want;
					if (m_tdata[0] !== want_word[0] || m_tdata[2:1] !== want_word[2:1]
						|| m_tdata[cpc_pkg::OUT_W-1:3] !== '0)
						note_mismatch($sformatf(
							"convex flag exp %b got %b, verdict exp %0d got %0d, pad got %h",
							want_word[0], m_tdata[0], want_word[2:1], m_tdata[2:1],
							m_tdata[cpc_pkg::OUT_W-1:3]));
				end
			end
			if (s_tvalid && s_tready) begin
				in_count++;
				vx = s_tdata[CW-1:0];
				vy = s_tdata[2*CW-1:CW];
				predict_vertex(vx, vy, s_tlast);
			end
		end
	end

	// vertex driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_count == offer_count)) begin
			if (vertex_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (vertex_q[0].drain && verdict_q.size() != 0) begin
				// let every outstanding result come back first
				s_tvalid <= 1'b0;
			end else if (tx_wait < vertex_q[0].gap) begin
				tx_wait++;
				s_tvalid <= 1'b0;
			end else begin
				tx_wait = 0;
				s_tdata <= {vertex_q[0].y, vertex_q[0].x};
				s_tlast <= vertex_q[0].last;
				s_tvalid <= 1'b1;
				void'(vertex_q.pop_front());
				offer_count++;
			end
		end
	end

	// one long back-pressure stretch once results are flowing
	always @(negedge clk) begin
		if (!hold_done && out_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_count != rx_seen) begin
				rx_seen = out_count;
				if ($urandom_range(0, 29) == 0)
					rx_fast = ~rx_fast;
				rx_wait = rx_fast ? 0 : int'($urandom_range(0, 19));
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

endmodule

@@ files.f @@
rtl/cpc_pkg.sv
rtl/cpc_front.sv
rtl/cpc_fifo.sv
rtl/cpc_back.sv
rtl/convex_polygon_check_core.sv
rtl/cpc_checker.sv
tb/convex_polygon_check_core_test.sv
